@@ sv/message_field_reader_top_macros.svh @@
// Assertion macros for the message field reader.
`ifndef MESSAGE_FIELD_READER_TOP_MACROS_SVH
`define MESSAGE_FIELD_READER_TOP_MACROS_SVH
`ifndef ASSERT_OFF
`define MFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`define MFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MFR_ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg)
`define MFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

@@ sv/mfr_pkg.sv @@
// Types, constants and helpers shared by the message field reader.
package mfr_pkg;

  localparam int unsigned CNT_W = 4;
  localparam logic [CNT_W-1:0] MAX_VARINT_BYTES = 4'd10;
  localparam int unsigned VARINT_BIT = 2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_TRUNC     = 2'd1,
    ST_MALFORMED = 2'd2
  } status_e;

  typedef struct packed {
    logic [2:0] operation;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last_in_view;
  } in_item_t;

  typedef struct packed {
    logic [63:0]      field_value;
    logic [1:0]       field_status;
    logic [CNT_W-1:0] bytes_used;
  } out_item_t;

  function automatic logic [63:0] width_mask(input logic [1:0] size_code);
    logic [63:0] m;
    unique case (size_code)
      2'd0:    m = 64'h0000_0000_0000_00ff;
      2'd1:    m = 64'h0000_0000_0000_ffff;
      2'd2:    m = 64'h0000_0000_ffff_ffff;
      default: m = 64'hffff_ffff_ffff_ffff;
    endcase
    return m;
  endfunction

endpackage

@@ sv/mfr_in_stage.sv @@
// Input register: holds one transfer until the decode stage takes it.
module mfr_in_stage (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  mfr_pkg::in_item_t in_data_i,
  input  logic              take_i,
  output logic              item_valid_o,
  output mfr_pkg::in_item_t item_o
);

  logic              valid_q, valid_d;
  mfr_pkg::in_item_t data_q;
  logic              accept;

  assign in_stall_o = valid_q & ~take_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign valid_d    = accept | (valid_q & ~take_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      data_q <= in_data_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = data_q;

endmodule

@@ sv/mfr_core.sv @@
// Field decode: accumulator state and the per-byte shift-or step.
module mfr_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  mfr_pkg::in_item_t  item_i,
  output logic               res_valid_o,
  output mfr_pkg::out_item_t res_o
);

  logic [63:0]              acc_q, acc_d;
  logic [mfr_pkg::CNT_W-1:0] cnt_q, cnt_d;
  logic [2:0]               kind_q, kind_d;
  logic                     in_field_q, in_field_d;

  logic [2:0]               kind;
  logic [63:0]              acc, acc_new;
  logic [mfr_pkg::CNT_W-1:0] cnt, cnt_inc, size;
  logic [6:0]               cnt_x7;
  logic [5:0]               var_shift;
  logic                     is_varint;
  mfr_pkg::status_e         err_status, status;
  logic                     done, ok;

  always_comb begin
    kind      = in_field_q ? kind_q : item_i.operation;
    acc       = in_field_q ? acc_q : 64'd0;
    cnt       = in_field_q ? cnt_q : '0;
    is_varint = kind[mfr_pkg::VARINT_BIT];
    err_status = is_varint ? mfr_pkg::ST_MALFORMED : mfr_pkg::ST_TRUNC;
    cnt_inc   = cnt + 4'd1;
    size      = 4'd1 << kind[1:0];
    cnt_x7    = {cnt, 3'b000} - {3'b000, cnt};
    var_shift = cnt_x7[5:0];
    acc_new   = acc;
    done      = 1'b0;
    ok        = 1'b0;
    status    = mfr_pkg::ST_OK;

    if (!item_i.byte_valid) begin
      done   = 1'b1;
      status = err_status;
    end else if (!is_varint) begin
      acc_new = acc | ({56'd0, item_i.data_byte} << {cnt[2:0], 3'b000});
      if (cnt_inc >= size) begin
        done = 1'b1;
        ok   = 1'b1;
      end else if (item_i.last_in_view) begin
        done   = 1'b1;
        status = mfr_pkg::ST_TRUNC;
      end
    end else begin
      if (cnt < mfr_pkg::MAX_VARINT_BYTES) begin
        acc_new = acc | ({57'd0, item_i.data_byte[6:0]} << var_shift);
      end
      if (!item_i.data_byte[7]) begin
        done = 1'b1;
        ok   = 1'b1;
      end else if (cnt_inc >= mfr_pkg::MAX_VARINT_BYTES || item_i.last_in_view) begin
        done   = 1'b1;
        status = mfr_pkg::ST_MALFORMED;
      end
    end
  end

  // a byte_valid of 0 reports the bytes already taken, not counting itself
  assign res_valid_o        = done;
  assign res_o.field_value  = ok ? (acc_new & mfr_pkg::width_mask(kind[1:0])) : 64'd0;
  assign res_o.field_status = status;
  assign res_o.bytes_used   = !item_i.byte_valid ? cnt : cnt_inc;

  always_comb begin
    kind_d     = kind_q;
    acc_d      = acc_q;
    cnt_d      = cnt_q;
    in_field_d = in_field_q;
    if (step_i) begin
      kind_d = kind;
      if (done) begin
        acc_d      = 64'd0;
        cnt_d      = '0;
        in_field_d = 1'b0;
      end else begin
        acc_d      = acc_new;
        cnt_d      = cnt_inc;
        in_field_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q      <= 64'd0;
      cnt_q      <= '0;
      kind_q     <= 3'd0;
      in_field_q <= 1'b0;
    end else begin
      acc_q      <= acc_d;
      cnt_q      <= cnt_d;
      kind_q     <= kind_d;
      in_field_q <= in_field_d;
    end
  end

endmodule

@@ sv/mfr_out_stage.sv @@
// Result register: holds a finished field until the sink takes it.
module mfr_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  mfr_pkg::out_item_t res_i,
  output logic               free_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mfr_pkg::out_item_t out_data_o
);

  logic               valid_q, valid_d;
  mfr_pkg::out_item_t data_q;

  assign free_o  = ~valid_q | ~out_stall_i;
  assign valid_d = load_i | (valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      data_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

@@ sv/message_field_reader_top.sv @@
// Top level of the message field reader.
//
//   channel | dir | payload              | handshake
//   in      | in  | mfr_pkg::in_item_t   | in_valid_i / in_stall_o
//   out     | out | mfr_pkg::out_item_t  | out_valid_o / out_stall_i
//
// One byte per cycle unless a stall holds the flow; a byte is decoded from the input register.
// A field result is loaded into the result register when its final byte is decoded.
// The decode step is one shift-or of the byte into the 64-bit accumulator.
// Reset and the end of each field return the core to idle; no clearing pass.
// A stalled output holds one result while the input register still takes a transfer.
`include "message_field_reader_top_macros.svh"
module message_field_reader_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  mfr_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output mfr_pkg::out_item_t out_data_o
);

  logic               item_valid;
  mfr_pkg::in_item_t  item;
  logic               out_free;
  logic               step;
  logic               res_valid;
  mfr_pkg::out_item_t res;

  assign step = item_valid & out_free;

  mfr_in_stage u_in_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .take_i      (step),
    .item_valid_o(item_valid),
    .item_o      (item)
  );

  mfr_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .item_i     (item),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  mfr_out_stage u_out_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (step & res_valid),
    .res_i      (res),
    .free_o     (out_free),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  `MFR_ASSERT_IMPL(a_err_value_zero, clk_i, rst_ni,
    out_valid_o && out_data_o.field_status != mfr_pkg::ST_OK,
    out_data_o.field_value == 64'd0, "failed field carries a value")
  `MFR_ASSERT_IMPL(a_bytes_bound, clk_i, rst_ni, out_valid_o,
    out_data_o.bytes_used <= mfr_pkg::MAX_VARINT_BYTES, "bytes_used beyond varint limit")
  `MFR_ASSERT_IMPL(a_stall_holds_item, clk_i, rst_ni, in_stall_o,
    item_valid && !step, "input stalled without a waiting item")
  `MFR_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, step && res_valid,
    out_valid_o, "finished field not registered")

endmodule
